// ----- rtl/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants for the address resolution cache.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;

    typedef enum logic
    {
        ACT_ADD    = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } arc_state_t;

    typedef struct packed
    {
        logic capture;
        logic write_entry;
        logic scan_clear;
        logic scan_issue;
        logic res_hit;
        logic res_miss;
        logic out_load;
    } arc_cmd_t;

    typedef struct packed
    {
        action_t action;
        logic    match;
        logic    scan_done;
        logic    rd_pending;
        logic    out_free;
    } arc_status_t;

endpackage

// ----- rtl/arc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arc_ctrl
// Controller state machine: accepts a transaction, runs an add or a lookup
// scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module arc_ctrl
    import arc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  arc_status_t status,
    output arc_cmd_t    cmd
);

    arc_state_t state_reg;
    arc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.action == ACT_ADD)
                begin
                    cmd.write_entry = 1'b1;
                    cmd.res_miss    = 1'b1;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The compare sees the entry read in the previous cycle, so the
                // first match found is always the lowest index.
                if (status.match)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (status.scan_done)
                begin
                    if (!status.rd_pending)
                    begin
                        cmd.res_miss = 1'b1;
                        state_next   = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while the output register is still held");

    a_issue_not_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> !status.scan_done)
        else $error("read issued beyond the last entry");

    a_accept_leads_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_EXEC)
        else $error("accepted transaction was not executed");

endmodule

// ----- rtl/arc_datapath.sv -----
// ----------------------------------------------------------------------------
// arc_datapath
// Entry memories, valid bits, replacement pointer, scan counter, compare and
// result registers.
// ----------------------------------------------------------------------------
module arc_datapath
    import arc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  arc_cmd_t           cmd,
    output arc_status_t        status,
    input  logic               action,
    input  logic [IP_W-1:0]    ip_address,
    input  logic [MAC_W-1:0]   mac_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [MAC_W-1:0]   found_mac
);

    logic [IP_W-1:0]    ip_mem [ENTRIES];
    logic [MAC_W-1:0]   mac_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;

    action_t            action_reg;
    logic [IP_W-1:0]    ip_reg;
    logic [MAC_W-1:0]   mac_reg;
    logic [IDX_W-1:0]   replace_ptr_reg;
    logic [IDX_W-1:0]   replace_ptr_next;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic [IDX_W-1:0]   scan_idx;
    logic               rd_pending_reg;
    logic               rd_vld_reg;
    logic [IP_W-1:0]    rd_ip_reg;
    logic [MAC_W-1:0]   rd_mac_reg;
    logic               res_hit_reg;
    logic [MAC_W-1:0]   res_mac_reg;
    logic               out_valid_reg;
    logic               hit_reg;
    logic [MAC_W-1:0]   found_mac_reg;
    logic               match;

    assign scan_idx = scan_cnt_reg[IDX_W-1:0];
    assign match    = rd_pending_reg && rd_vld_reg && (rd_ip_reg == ip_reg);

    assign replace_ptr_next = (replace_ptr_reg == IDX_W'(ENTRIES - 1)) ?
                              '0 : replace_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ip_reg  <= ip_address;
            mac_reg <= mac_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_ADD;
        end
        else if (cmd.capture)
        begin
            action_reg <= action_t'(action);
        end
    end

    // Entry memories: one write port at the replacement pointer, one
    // registered read port at the scan index.
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            ip_mem[replace_ptr_reg]  <= ip_reg;
            mac_mem[replace_ptr_reg] <= mac_reg;
        end
        if (cmd.scan_issue)
        begin
            rd_ip_reg  <= ip_mem[scan_idx];
            rd_mac_reg <= mac_mem[scan_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            replace_ptr_reg <= '0;
            scan_cnt_reg    <= '0;
            rd_pending_reg  <= 1'b0;
            rd_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.write_entry)
            begin
                valid_reg[replace_ptr_reg] <= 1'b1;
                replace_ptr_reg            <= replace_ptr_next;
            end
            if (cmd.scan_clear)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            rd_pending_reg <= cmd.scan_issue;
            if (cmd.scan_issue)
            begin
                rd_vld_reg <= valid_reg[scan_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_hit_reg <= 1'b0;
        end
        else if (cmd.res_hit)
        begin
            res_hit_reg <= 1'b1;
        end
        else if (cmd.res_miss)
        begin
            res_hit_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_hit)
        begin
            res_mac_reg <= rd_mac_reg;
        end
        else if (cmd.res_miss)
        begin
            res_mac_reg <= '0;
        end
        if (cmd.out_load)
        begin
            found_mac_reg <= res_mac_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= res_hit_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign found_mac = found_mac_reg;

    assign status.action     = action_reg;
    assign status.match      = match;
    assign status.scan_done  = (scan_cnt_reg == CNT_W'(ENTRIES));
    assign status.rd_pending = rd_pending_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |=> valid_reg[$past(replace_ptr_reg)])
        else $error("written entry not marked valid");

    a_pointer_advances: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |=> replace_ptr_reg != $past(replace_ptr_reg))
        else $error("replacement pointer did not advance after a write");

    a_valid_never_drops: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) >= $countones($past(valid_reg)))
        else $error("a valid entry was lost");

endmodule

// ----- rtl/address_resolution_cache.sv -----
// ----------------------------------------------------------------------------
// address_resolution_cache
// IPv4-to-MAC address table with round-robin replacement and an in-order
// lookup scan.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -------------------------------------
//   input    in_valid / in_stall    action, ip_address, mac_address
//   output   out_valid / out_stall  hit, found_mac
//
// An add passes from acceptance through the execute and finish states back
// to idle. A lookup scans the entries through the single read port of the
// entry memory, lowest index first; a hit ends the scan early.
// Reset clears the valid bits and the replacement pointer at once.
// A new transaction is accepted in idle while a finished result waits in the
// output register; the block only holds in the finish state when a second
// result is ready before the first has been taken.
// ----------------------------------------------------------------------------
module address_resolution_cache
    import arc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [IP_W-1:0]    ip_address,
    input  logic [MAC_W-1:0]   mac_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [MAC_W-1:0]   found_mac
);

    arc_cmd_t    cmd;
    arc_status_t status;

    arc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    arc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .action      (action),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .found_mac   (found_mac)
    );

endmodule
